/* src/bcdc_pkg.sv */
// package for the cross dilation counter: sizes, register codes and shared types
// used by every module of the block; no dependencies
`default_nettype none

package bcdc_pkg;

  localparam int unsigned MAX_COLUMNS = 32;
  localparam int unsigned MAX_ROWS    = 1024;

  localparam int unsigned COL_W      = $clog2(MAX_COLUMNS);
  localparam int unsigned ROW_W      = $clog2(MAX_ROWS);
  localparam int unsigned COLCNT_W   = 6;
  localparam int unsigned ROWCNT_W   = 11;
  localparam int unsigned TOTAL_W    = 16;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 11;
  localparam int unsigned IN_DATA_W  = 8;
  localparam int unsigned OUT_DATA_W = 40;

  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLUMN_COUNT = 2'd1;

  localparam logic [ROWCNT_W-1:0] ROW_RESET = 11'd32;
  localparam logic [COLCNT_W-1:0] COL_RESET = 6'd32;

  // one row store entry: the row just finished and the one before it
  typedef struct packed {
    logic prev;
    logic older;
  } row_word_t;

  typedef struct packed {
    logic             en;
    logic [COL_W-1:0] addr;
    row_word_t        data;
  } mem_wr_t;

  // one cell handed to the dilation stage
  typedef struct packed {
    logic             din;
    logic [COL_W-1:0] col;
    logic             left_en;
    logic             right_en;
    logic             up_en;
    logic             down_en;
    logic             emit;
    logic             last;
    logic             wr_en;
  } issue_t;

endpackage

`default_nettype wire

/* src/bcdc_row_mem.sv */
// row store: column-indexed memory holding the two finished rows
// synchronous read with write-to-read forwarding; uses bcdc_pkg
`default_nettype none

module bcdc_row_mem (
  input  wire                         clk_i,
  input  wire                         rd_en_i,
  input  wire  [bcdc_pkg::COL_W-1:0]  rd_addr_i,
  input  wire  bcdc_pkg::mem_wr_t     wr_i,
  output bcdc_pkg::row_word_t         rd_data_o
);
  import bcdc_pkg::*;

  row_word_t mem_q [MAX_COLUMNS];

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      if (wr_i.en && (wr_i.addr == rd_addr_i)) begin
        rd_data_o <= wr_i.data;
      end else begin
        rd_data_o <= mem_q[rd_addr_i];
      end
    end
  end

endmodule

`default_nettype wire

/* src/bcdc_seq.sv */
// sequencer: configuration registers, raster position and end-of-grid flush
// issues one cell per cycle toward the dilation stage while it has a free slot; uses bcdc_pkg
`default_nettype none

module bcdc_seq (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  wire                             s_axis_tvalid,
  output logic                            s_axis_tready,
  input  wire                             cell_i,
  input  wire                             cfg_valid_i,
  output logic                            cfg_ready_o,
  input  wire  [bcdc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire  [bcdc_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  wire                             slot_free_i,
  output logic                            issue_valid_o,
  output bcdc_pkg::issue_t                issue_o,
  output logic [bcdc_pkg::COL_W-1:0]      rd_addr_o,
  output logic [bcdc_pkg::TOTAL_W-1:0]    total_o,
  output logic                            restart_o,
  output logic                            flush_o
);
  import bcdc_pkg::*;

  logic [ROWCNT_W-1:0] row_cnt_q, row_cnt_d;
  logic [COLCNT_W-1:0] col_cnt_q, col_cnt_d;
  logic [COL_W-1:0]    col_q, col_d, fcol_q, fcol_d;
  logic [ROW_W-1:0]    row_q, row_d;
  logic                flush_q, flush_d;
  logic [TOTAL_W-1:0]  total_q;
  logic [ROWCNT_W+COLCNT_W-1:0] product;

  logic                cfg_we, cfg_hit;
  logic [COLCNT_W-1:0] cfg_col_raw;
  logic [COL_W-1:0]    cur_col;
  logic                last_col, last_row, issue_fire;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;
  // writes beyond the register list change nothing
  assign cfg_hit     = cfg_we && ((cfg_index_i == REG_ROW_COUNT) ||
                                  (cfg_index_i == REG_COLUMN_COUNT));
  assign restart_o   = cfg_hit;
  assign cfg_col_raw = cfg_data_i[COLCNT_W-1:0];

  assign cur_col  = flush_q ? fcol_q : col_q;
  assign last_col = (COLCNT_W'(cur_col) + COLCNT_W'(1)) == col_cnt_q;
  assign last_row = (ROWCNT_W'(row_q) + ROWCNT_W'(1)) == row_cnt_q;

  assign s_axis_tready = !flush_q && slot_free_i;
  assign issue_valid_o = flush_q || s_axis_tvalid;
  assign issue_fire    = issue_valid_o && slot_free_i;
  assign rd_addr_o     = last_col ? '0 : COL_W'(cur_col + COL_W'(1));
  assign flush_o       = flush_q;
  assign total_o       = total_q;
  assign product       = row_cnt_q * col_cnt_q;

  always_comb begin
    issue_o.col      = cur_col;
    issue_o.left_en  = cur_col != '0;
    issue_o.right_en = !last_col;
    if (flush_q) begin
      issue_o.din     = 1'b0;
      issue_o.up_en   = row_cnt_q[ROWCNT_W-1:1] != '0;
      issue_o.down_en = 1'b0;
      issue_o.emit    = 1'b1;
      issue_o.last    = last_col;
      issue_o.wr_en   = 1'b0;
    end else begin
      issue_o.din     = cell_i;
      issue_o.up_en   = row_q[ROW_W-1:1] != '0;
      issue_o.down_en = 1'b1;
      issue_o.emit    = row_q != '0;
      issue_o.last    = 1'b0;
      issue_o.wr_en   = 1'b1;
    end
  end

  always_comb begin
    row_cnt_d = row_cnt_q;
    col_cnt_d = col_cnt_q;
    col_d     = col_q;
    row_d     = row_q;
    fcol_d    = fcol_q;
    flush_d   = flush_q;
    if (cfg_hit) begin
      unique case (cfg_index_i)
        REG_ROW_COUNT: begin
          if (cfg_data_i == '0) begin
            row_cnt_d = ROWCNT_W'(1);
          end else if (cfg_data_i > CFG_DATA_W'(MAX_ROWS)) begin
            row_cnt_d = ROWCNT_W'(MAX_ROWS);
          end else begin
            row_cnt_d = cfg_data_i;
          end
        end
        REG_COLUMN_COUNT: begin
          if (cfg_col_raw == '0) begin
            col_cnt_d = COLCNT_W'(1);
          end else if (cfg_col_raw > COLCNT_W'(MAX_COLUMNS)) begin
            col_cnt_d = COLCNT_W'(MAX_COLUMNS);
          end else begin
            col_cnt_d = cfg_col_raw;
          end
        end
        default: begin
        end
      endcase
      col_d   = '0;
      row_d   = '0;
      fcol_d  = '0;
      flush_d = 1'b0;
    end else if (issue_fire) begin
      if (flush_q) begin
        fcol_d = COL_W'(fcol_q + COL_W'(1));
        if (last_col) begin
          flush_d = 1'b0;
        end
      end else if (last_col) begin
        col_d = '0;
        if (last_row) begin
          row_d   = '0;
          fcol_d  = '0;
          flush_d = 1'b1;
        end else begin
          row_d = ROW_W'(row_q + ROW_W'(1));
        end
      end else begin
        col_d = COL_W'(col_q + COL_W'(1));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_cnt_q <= ROW_RESET;
      col_cnt_q <= COL_RESET;
      col_q     <= '0;
      row_q     <= '0;
      fcol_q    <= '0;
      flush_q   <= 1'b0;
    end else begin
      row_cnt_q <= row_cnt_d;
      col_cnt_q <= col_cnt_d;
      col_q     <= col_d;
      row_q     <= row_d;
      fcol_q    <= fcol_d;
      flush_q   <= flush_d;
    end
  end

  always_ff @(posedge clk_i) begin
    total_q <= product[TOTAL_W-1:0];
  end

endmodule

`default_nettype wire

/* src/bcdc_dilate.sv */
// dilation stage: cross neighborhood from the row store window, tally and output register
// writes each input cell back into the row store; uses bcdc_pkg
`default_nettype none

module bcdc_dilate (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           issue_valid_i,
  input  wire  bcdc_pkg::issue_t        issue_i,
  output logic                          slot_free_o,
  input  wire  bcdc_pkg::row_word_t     rd_data_i,
  output bcdc_pkg::mem_wr_t             wr_o,
  input  wire  [bcdc_pkg::TOTAL_W-1:0]  total_i,
  input  wire                           restart_i,
  output logic                          m_axis_tvalid,
  input  wire                           m_axis_tready,
  output logic [bcdc_pkg::OUT_DATA_W-1:0] m_axis_tdata, // flooded, dry_total, wet_total
  output logic                          m_axis_tlast
);
  import bcdc_pkg::*;

  issue_t             s1_q;
  logic               s1_valid_q;
  row_word_t          win_q;
  logic               left_q;
  logic [TOTAL_W-1:0] tally_q, tally_d, wet_sum;

  logic               out_valid_q;
  logic               flooded_q, last_q;
  logic [TOTAL_W-1:0] dry_q, wet_q;

  logic value, out_free, adv;

  assign value = win_q.prev
              | (s1_q.left_en  & left_q)
              | (s1_q.right_en & rd_data_i.prev)
              | (s1_q.up_en    & win_q.older)
              | (s1_q.down_en  & s1_q.din);

  assign out_free    = !out_valid_q || m_axis_tready;
  assign adv         = s1_valid_q && (!s1_q.emit || out_free);
  assign slot_free_o = !s1_valid_q || adv;
  assign wet_sum     = TOTAL_W'(tally_q + TOTAL_W'(value));

  assign wr_o.en         = adv && s1_q.wr_en;
  assign wr_o.addr       = s1_q.col;
  assign wr_o.data.prev  = s1_q.din;
  assign wr_o.data.older = win_q.prev;

  always_comb begin
    tally_d = tally_q;
    if (restart_i) begin
      tally_d = '0;
    end else if (adv && s1_q.emit) begin
      tally_d = s1_q.last ? '0 : wet_sum;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      tally_q     <= '0;
    end else begin
      tally_q <= tally_d;
      if (slot_free_o) begin
        s1_valid_q <= issue_valid_i;
      end
      if (adv && s1_q.emit) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (slot_free_o && issue_valid_i) begin
      s1_q <= issue_i;
    end
    if (adv) begin
      // single-column grid: the next cell needs the entry written right now
      if (s1_q.wr_en && !s1_q.left_en && !s1_q.right_en) begin
        win_q <= wr_o.data;
      end else begin
        win_q <= rd_data_i;
      end
      left_q <= win_q.prev;
    end
    if (adv && s1_q.emit) begin
      flooded_q <= value;
      last_q    <= s1_q.last;
      if (s1_q.last) begin
        wet_q <= wet_sum;
        dry_q <= TOTAL_W'(total_i - wet_sum);
      end else begin
        wet_q <= '0;
        dry_q <= '0;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tlast  = last_q;
  assign m_axis_tdata  = {(OUT_DATA_W - 2*TOTAL_W - 1)'(0), wet_q, dry_q, flooded_q};

endmodule

`default_nettype wire

/* src/binary_cross_dilation_counter_core.sv */
// top level of the cross dilation counter: sequencer, row store and dilation stage
// uses bcdc_pkg, bcdc_seq, bcdc_row_mem and bcdc_dilate
// a result is formed in the dilation stage from the input cell one row below it and leaves
// through the output register; the final row is flushed after the last cell of the grid;
// input is held off during that flush. throughput: one cell per cycle unless the output
// stalls, set by the single read and write port of the row store. reset clears positions,
// the tally and the configuration (32 rows, 32 columns); the row store is not cleared
`default_nettype none

module binary_cross_dilation_counter_core (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              s_axis_tvalid,
  output logic                             s_axis_tready,
  input  wire  [bcdc_pkg::IN_DATA_W-1:0]   s_axis_tdata, // cell_req
  output logic                             m_axis_tvalid,
  input  wire                              m_axis_tready,
  output logic [bcdc_pkg::OUT_DATA_W-1:0]  m_axis_tdata, // flooded, dry_total, wet_total
  output logic                             m_axis_tlast,
  input  wire                              cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire  [bcdc_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire  [bcdc_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import bcdc_pkg::*;

  logic               slot_free, issue_valid, restart, flush;
  issue_t             issue;
  logic [COL_W-1:0]   rd_addr;
  logic [TOTAL_W-1:0] total;
  row_word_t          rd_data;
  mem_wr_t            wr;

  bcdc_seq u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .cell_i        (s_axis_tdata[0]),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .slot_free_i   (slot_free),
    .issue_valid_o (issue_valid),
    .issue_o       (issue),
    .rd_addr_o     (rd_addr),
    .total_o       (total),
    .restart_o     (restart),
    .flush_o       (flush)
  );

  bcdc_row_mem u_mem (
    .clk_i     (clk_i),
    .rd_en_i   (issue_valid && slot_free),
    .rd_addr_i (rd_addr),
    .wr_i      (wr),
    .rd_data_o (rd_data)
  );

  bcdc_dilate u_dilate (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .issue_valid_i (issue_valid),
    .issue_i       (issue),
    .slot_free_o   (slot_free),
    .rd_data_i     (rd_data),
    .wr_o          (wr),
    .total_i       (total),
    .restart_i     (restart),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  // input is held off while the final row drains
  a_flush_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    flush |-> !s_axis_tready)
    else $error("input taken during flush");

  // totals only on the final result of the grid
  a_totals_only_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tlast) |-> (m_axis_tdata[OUT_DATA_W-1:1] == '0))
    else $error("nonzero totals before end of grid");

  // dry and wet totals add up to the grid size
  a_totals_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tlast) |->
      (TOTAL_W'(m_axis_tdata[TOTAL_W:1] + m_axis_tdata[2*TOTAL_W:TOTAL_W+1]) == total))
    else $error("totals do not cover the grid");

  // a stalled result holds steady until its transfer
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
    else $error("result changed while stalled");

endmodule

`default_nettype wire

/* test/bcdc_checker.sv */
`timescale 1ns / 100ps
// result checker for the cross dilation counter testbench: watches the cell, result and
// register channels, predicts every dilated cell and compares it; depends on bcdc_pkg
module bcdc_checker (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  wire                             cell_valid_i,
  input  wire                             cell_ready_i,
  input  wire  [bcdc_pkg::IN_DATA_W-1:0]  cell_data_i,  // cell_req
  input  wire                             res_valid_i,
  input  wire                             res_ready_i,
  input  wire  [bcdc_pkg::OUT_DATA_W-1:0] res_data_i,   // flooded, dry_total, wet_total
  input  wire                             res_last_i,
  input  wire                             cfg_valid_i,
  input  wire                             cfg_ready_i,
  input  wire  [bcdc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire  [bcdc_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output int                              fails_o,
  output int                              pending_o
);
  import bcdc_pkg::*;

  localparam int DRY_LSB = 1;
  localparam int WET_LSB = DRY_LSB + TOTAL_W;

  typedef struct packed {
    logic               flooded;
    logic [TOTAL_W-1:0] dry_total;
    logic [TOTAL_W-1:0] wet_total;
    logic               last;
  } dilated_t;

  logic [ROWCNT_W-1:0]    row_count;
  logic [COLCNT_W-1:0]    column_count;
  logic [MAX_COLUMNS-1:0] older_row, prev_row, cur_row;
  int unsigned            col_pos, row_pos;
  logic [TOTAL_W-1:0]     wet_tally;
  dilated_t               dilated_q[$];
  int                     fail_total = 0;

  function automatic int unsigned grid_rows();
    if (row_count == '0) return 1;
    if (row_count > MAX_ROWS) return MAX_ROWS;
    return row_count;
  endfunction

  function automatic int unsigned grid_cols();
    if (column_count == '0) return 1;
    if (column_count > MAX_COLUMNS) return MAX_COLUMNS;
    return column_count;
  endfunction

  function automatic logic cross_at(input logic [MAX_COLUMNS-1:0] up, input logic up_en,
                                    input logic [MAX_COLUMNS-1:0] mid,
                                    input logic [MAX_COLUMNS-1:0] down, input logic down_en,
                                    input int unsigned c, input int unsigned ncols);
    logic v;
    v = mid[c] | (up_en & up[c]) | (down_en & down[c]);
    if (c > 0) v = v | mid[c-1];
    if (c + 1 < ncols) v = v | mid[c+1];
    return v;
  endfunction

  task automatic restart_pass();
    col_pos   = 0;
    row_pos   = 0;
    wet_tally = '0;
  endtask

  task automatic push_cell(input logic v, input logic is_last, input logic [TOTAL_W-1:0] total);
    dilated_t e;
    wet_tally   = wet_tally + TOTAL_W'(v);
    e.flooded   = v;
    e.dry_total = is_last ? total - wet_tally : '0;
    e.wet_total = is_last ? wet_tally : '0;
    e.last      = is_last;
    dilated_q.push_back(e);
  endtask

  task automatic take_cell(input logic cell_val);
    int unsigned        nr, nc, c, r, j;
    logic [TOTAL_W-1:0] total;
    nr = grid_rows();
    nc = grid_cols();
    c  = col_pos;
    r  = row_pos;
    if (c >= nc || r >= nr) begin
      restart_pass();
      c = 0;
      r = 0;
    end
    cur_row[c] = cell_val;
    if (r >= 1) push_cell(cross_at(older_row, r >= 2, prev_row, cur_row, 1'b1, c, nc), 1'b0, '0);
    if (c + 1 < nc) begin
      col_pos = c + 1;
    end else if (r + 1 < nr) begin
      older_row = prev_row;
      prev_row  = cur_row;
      col_pos   = 0;
      row_pos   = r + 1;
    end else begin
      // final row flush, totals ride on the last transfer
      total = TOTAL_W'(nr * nc);
      for (j = 0; j < nc; j++) begin
        push_cell(cross_at(prev_row, r >= 1, cur_row, '0, 1'b0, j, nc), j + 1 == nc, total);
      end
      restart_pass();
    end
  endtask

  task automatic check_result(input logic [OUT_DATA_W-1:0] data, input logic last);
    dilated_t e;
    if (dilated_q.size() == 0) begin
      $error("result transfer with nothing due: data %h last %b", data, last);
      fail_total++;
    end else begin
      e = dilated_q.pop_front();
      if (data[0] !== e.flooded) begin
        $error("flooded: expected %0d, actual %0d", e.flooded, data[0]);
        fail_total++;
      end
      if (data[DRY_LSB +: TOTAL_W] !== e.dry_total) begin
        $error("dry_total: expected %0d, actual %0d", e.dry_total, data[DRY_LSB +: TOTAL_W]);
        fail_total++;
      end
      if (data[WET_LSB +: TOTAL_W] !== e.wet_total) begin
        $error("wet_total: expected %0d, actual %0d", e.wet_total, data[WET_LSB +: TOTAL_W]);
        fail_total++;
      end
      if (last !== e.last) begin
        $error("last: expected %0d, actual %0d", e.last, last);
        fail_total++;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_count    = ROW_RESET;
      column_count = COL_RESET;
      older_row    = '0;
      prev_row     = '0;
      cur_row      = '0;
      restart_pass();
      dilated_q.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_ROW_COUNT: begin
            row_count = cfg_data_i[ROWCNT_W-1:0];
            restart_pass();
          end
          REG_COLUMN_COUNT: begin
            column_count = cfg_data_i[COLCNT_W-1:0];
            restart_pass();
          end
          default: ;
        endcase
      end
      if (res_valid_i && res_ready_i) check_result(res_data_i, res_last_i);
      if (cell_valid_i && cell_ready_i) take_cell(cell_data_i[0]);
    end
    pending_o <= dilated_q.size();
    fails_o   <= fail_total;
  end

endmodule

/* test/testbench.sv */
`timescale 1ns / 100ps
// top of the cross dilation counter testbench: clock, reset, cell and register stimulus,
// result back-pressure, watchdog and verdict; depends on bcdc_pkg, bcdc_checker and the core
module testbench;
  import bcdc_pkg::*;

  localparam int DRAIN      = 40;
  localparam int LONG_HOLD  = 300;
  localparam int IDLE_LIMIT = 2000;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

  logic                  clk_i     = 1'b0;
  logic                  rst_ni    = 1'b0;
  logic                  s_tvalid  = 1'b0;
  logic [IN_DATA_W-1:0]  s_tdata   = '0;
  wire                   s_tready;
  wire                   m_tvalid;
  logic                  m_tready  = 1'b0;
  wire  [OUT_DATA_W-1:0] m_tdata;
  wire                   m_tlast;
  logic                  cfg_valid = 1'b0;
  wire                   cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  logic                  quiet     = 1'b0;
  logic                  hold_req  = 1'b0;
  int                    fails, pending;
  int                    cells_sent = 0;
  int                    grids_sent = 0;

  binary_cross_dilation_counter_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata),
    .m_axis_tlast  (m_tlast),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data)
  );

  bcdc_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cell_valid_i (s_tvalid),
    .cell_ready_i (s_tready),
    .cell_data_i  (s_tdata),
    .res_valid_i  (m_tvalid),
    .res_ready_i  (m_tready),
    .res_data_i   (m_tdata),
    .res_last_i   (m_tlast),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .fails_o      (fails),
    .pending_o    (pending)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  task automatic send_cell(input logic v);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= IN_DATA_W'(v);
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
    cells_sent++;
  endtask

  task automatic send_pattern(input logic [31:0] bits, input int n);
    for (int i = 0; i < n; i++) send_cell(bits[i]);
    grids_sent++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
  endtask

  // let every dilated cell drain, plus a final-row flush worth of cycles
  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
  endtask

  task automatic configure(input logic [CFG_DATA_W-1:0] rows, input logic [CFG_DATA_W-1:0] cols);
    settle();
    write_reg(REG_ROW_COUNT, rows);
    write_reg(REG_COLUMN_COUNT, cols);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_grids(input int cells, input int passes, input int pct, input int pause_at);
    int density;
    for (int p = 0; p < passes; p++) begin
      density = (pct < 0) ? $urandom_range(5, 95) : pct;
      for (int k = 0; k < cells; k++) begin
        if (p == 0 && k == pause_at) begin
          s_tvalid <= 1'b0;
          @(posedge clk_i);
          while (pending != 0) @(posedge clk_i);
        end
        send_cell($urandom_range(1, 100) <= density);
      end
    end
    grids_sent += passes;
  endtask

  // result side back-pressure
  initial begin
    bit long_done;
    long_done = 1'b0;
    @(posedge clk_i);
    forever begin
      if (hold_req && !long_done) begin
        long_done = 1'b1;
        m_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk_i);
      end else begin
        m_tready <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  initial begin
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
        idle = 0;
      else
        idle++;
    end
    $display("timeout after %0d cycles without a transfer", IDLE_LIMIT);
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    int r, c;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // zero counts read as a single cell grid
    configure(11'd0, 11'd0);
    send_pattern(32'b1, 1);
    send_pattern(32'b0, 1);
    // writes beyond the register list change nothing
    settle();
    write_reg(REG_SPARE_2, 11'h7FF);
    write_reg(REG_SPARE_3, 11'h555);
    cfg_valid <= 1'b0;
    send_pattern(32'b1, 1);
    configure(11'd3, 11'd3);
    send_pattern(32'b000010000, 9);
    send_pattern(32'b100000001, 9);
    // single row, upper column bits dropped
    configure(11'd1, 11'h7C5);
    send_pattern(32'b10101, 5);

    configure(11'd2, 11'd4);
    run_grids(8, 2, -1, -1);
    configure(11'd5, 11'd7);
    run_grids(35, 1, -1, 20);
    configure(11'd1, 11'd32);
    run_grids(32, 1, -1, -1);
    // column count saturates, output held off while cells keep coming
    configure(11'd2, 11'h7E1);
    hold_req <= 1'b1;
    run_grids(64, 1, 50, -1);
    configure(11'd7, 11'd1);
    run_grids(7, 1, -1, -1);
    // row count saturates; partial grid, then a register write restarts it
    configure(11'h7FF, 11'd1);
    for (int k = 0; k < 10; k++) send_cell(1'($urandom_range(0, 1)));
    configure(11'd6, 11'd3);
    run_grids(18, 1, -1, -1);
    configure(11'd0, 11'h7C3);
    run_grids(3, 2, -1, -1);
    repeat (2) begin
      r = $urandom_range(1, 6);
      c = $urandom_range(1, 10);
      configure(CFG_DATA_W'(r), CFG_DATA_W'(c));
      run_grids(r * c, 1, -1, -1);
    end
    configure(11'd3, 11'd8);
    quiet <= 1'b1;
    run_grids(24, 1, -1, -1);

    settle();
    $display("sent %0d cells in %0d grids, sizes from 1x1 up to 2x32, single rows and columns",
             cells_sent, grids_sent);
    $display("included a mid-grid restart, a %0d-cycle output stall and a drain pause",
             LONG_HOLD);
    if (fails == 0 && pending == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
